// ===== sv/frame_free_list_allocator_defines.svh =====
// ----------------------------------------------------------------------------
// Frame free list allocator: assertion macros
// Shared macros for the concurrent checks on the allocator ports.
// ----------------------------------------------------------------------------
`ifndef FRAME_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define FRAME_FREE_LIST_ALLOCATOR_DEFINES_SVH

// check a property while out of reset
`define FFLA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("frame allocator check failed");

// check a property on every edge, reset included
`define FFLA_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("frame allocator reset check failed");

`endif

// ===== sv/ffla_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame free list allocator package
// Widths, op codes, state encoding and the link memory request word.
// ----------------------------------------------------------------------------
package ffla_pkg;

    localparam int FRAME_BITS = 16;
    localparam int NUM_FRAMES = 1 << FRAME_BITS;
    localparam int FIELD_W    = 16;
    localparam int SUM_W      = ((FRAME_BITS > FIELD_W) ? FRAME_BITS : FIELD_W) + 1;

    typedef logic [FRAME_BITS-1:0] frame_t;
    typedef logic [FIELD_W-1:0]    field_t;
    typedef logic [SUM_W-1:0]      sum_t;

    localparam frame_t FRAME_MASK     = '1;
    localparam field_t LOW_MARK_RESET = 16'd256;  // frame 256

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ALLOC_WAIT,
        ST_ADD_CHAIN,
        ST_ADD_LINK
    } state_t;

    typedef struct packed {
        logic   we;
        frame_t waddr;
        frame_t wdata;
        logic   re;
        frame_t raddr;
    } mem_req_t;

endpackage

// ===== sv/ffla_link_ram.sv =====
// ----------------------------------------------------------------------------
// Frame free list allocator: link RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ffla_link_ram #(
    parameter int ADDR_W = 16,
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/ffla_ctrl.sv =====
// ----------------------------------------------------------------------------
// Frame free list allocator: control
// Op sequencer, list head and tail, config register and result register.
// ----------------------------------------------------------------------------
module ffla_ctrl (
    input  logic              clk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_op,
    input  ffla_pkg::field_t  s_region_start,
    input  ffla_pkg::field_t  s_region_pages,
    input  logic              s_region_usable,
    input  ffla_pkg::field_t  s_release_frame,
    output logic              m_valid,
    input  logic              m_ready,
    output ffla_pkg::field_t  m_granted_frame,
    output logic              m_out_of_memory,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  ffla_pkg::field_t  cfg_wdata,
    output ffla_pkg::mem_req_t mem_req,
    input  ffla_pkg::frame_t  mem_rdata
);

    import ffla_pkg::*;

    state_t state_reg, state_next;
    op_t    op_reg;
    field_t start_reg, pages_reg, release_reg;
    logic   usable_reg;
    field_t low_mark_reg;
    frame_t head_reg, head_next;
    frame_t tail_reg, tail_next;
    frame_t cur_reg, cur_next;
    frame_t last_reg, last_next;
    frame_t first_reg, first_next;
    logic   m_valid_reg, m_valid_next;
    field_t granted_reg, granted_next;
    logic   oom_reg, oom_next;

    logic   slot_free;
    frame_t first_raw, first_adj, last_clip, rel_frame;
    logic   zero_first, add_skip;
    field_t pages_adj;
    sum_t   last_sum;

    assign s_ready         = (state_reg == ST_IDLE);
    assign cfg_ready       = 1'b1;
    assign m_valid         = m_valid_reg;
    assign m_granted_frame = granted_reg;
    assign m_out_of_memory = oom_reg;
    assign slot_free       = !m_valid_reg || m_ready;

    // region bounds: skip frame zero, clip at the top frame
    always_comb begin
        first_raw  = frame_t'(start_reg);
        zero_first = (first_raw == '0);
        first_adj  = zero_first ? frame_t'(1) : first_raw;
        pages_adj  = zero_first ? (pages_reg - field_t'(1)) : pages_reg;
        add_skip   = !usable_reg || (start_reg < low_mark_reg) ||
                     (pages_reg == '0) || (pages_adj == '0);
        last_sum   = sum_t'(first_adj) + sum_t'(pages_adj) - sum_t'(1);
        last_clip  = (last_sum > sum_t'(FRAME_MASK)) ? FRAME_MASK : frame_t'(last_sum);
        rel_frame  = frame_t'(release_reg);
    end

    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        cur_next     = cur_reg;
        last_next    = last_reg;
        first_next   = first_reg;
        m_valid_next = m_valid_reg && !m_ready;
        granted_next = granted_reg;
        oom_next     = oom_reg;
        mem_req      = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (op_reg)
                    OP_ADD: begin
                        if (add_skip) begin
                            if (slot_free) begin
                                m_valid_next = 1'b1;
                                granted_next = '0;
                                oom_next     = 1'b0;
                                state_next   = ST_IDLE;
                            end
                        end else begin
                            first_next = first_adj;
                            cur_next   = first_adj;
                            last_next  = last_clip;
                            state_next = ST_ADD_CHAIN;
                        end
                    end
                    OP_ALLOC: begin
                        if (head_reg != '0) begin
                            mem_req.re    = 1'b1;
                            mem_req.raddr = head_reg;
                            state_next    = ST_ALLOC_WAIT;
                        end else if (slot_free) begin
                            m_valid_next = 1'b1;
                            granted_next = '0;
                            oom_next     = 1'b1;
                            state_next   = ST_IDLE;
                        end
                    end
                    OP_FREE: begin
                        if (slot_free) begin
                            // push: new frame links to the old head
                            if (rel_frame != '0) begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = rel_frame;
                                mem_req.wdata = head_reg;
                                head_next     = rel_frame;
                            end
                            m_valid_next = 1'b1;
                            granted_next = '0;
                            oom_next     = 1'b0;
                            state_next   = ST_IDLE;
                        end
                    end
                    default: begin
                        if (slot_free) begin
                            m_valid_next = 1'b1;
                            granted_next = '0;
                            oom_next     = 1'b0;
                            state_next   = ST_IDLE;
                        end
                    end
                endcase
            end
            ST_ALLOC_WAIT: begin
                // pop: link of the old head becomes the new head
                if (slot_free) begin
                    head_next    = mem_rdata;
                    m_valid_next = 1'b1;
                    granted_next = field_t'(head_reg);
                    oom_next     = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            ST_ADD_CHAIN: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = cur_reg;
                if (cur_reg != last_reg) begin
                    mem_req.wdata = cur_reg + frame_t'(1);
                    cur_next      = cur_reg + frame_t'(1);
                end else begin
                    mem_req.wdata = '0;
                    state_next    = ST_ADD_LINK;
                end
            end
            ST_ADD_LINK: begin
                if (slot_free) begin
                    // append after the previous region's tail
                    if (tail_reg != '0) begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = tail_reg;
                        mem_req.wdata = first_reg;
                    end
                    tail_next = last_reg;
                    if (head_reg == '0) begin
                        head_next = first_reg;
                    end
                    m_valid_next = 1'b1;
                    granted_next = '0;
                    oom_next     = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            m_valid_reg  <= 1'b0;
            low_mark_reg <= LOW_MARK_RESET;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                low_mark_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk) begin
        cur_reg     <= cur_next;
        last_reg    <= last_next;
        first_reg   <= first_next;
        granted_reg <= granted_next;
        oom_reg     <= oom_next;
        if (s_valid && s_ready) begin
            op_reg      <= op_t'(s_op);
            start_reg   <= s_region_start;
            pages_reg   <= s_region_pages;
            usable_reg  <= s_region_usable;
            release_reg <= s_release_frame;
        end
    end

endmodule

// ===== sv/frame_free_list_allocator.sv =====
// Steps: free, unused op and skipped add go from accept through decode to the result;
// allocate adds one link RAM read; add region writes one link per page, with
// pages counted after frame zero is dropped and the region is clipped at the top.
// Throughput: one item at a time, the next word is taken as the result appears;
// add region writes one link per cycle.
// Reset: head, tail, result valid clear; low mark back to frame 256; link RAM kept.
// ----------------------------------------------------------------------------
// Frame free list allocator
// Free frame stack (regions appended at the tail) linked through a next-frame RAM, frame 0 as null mark.
// ----------------------------------------------------------------------------
module frame_free_list_allocator (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_op,
    input  ffla_pkg::field_t s_region_start,
    input  ffla_pkg::field_t s_region_pages,
    input  logic             s_region_usable,
    input  ffla_pkg::field_t s_release_frame,
    output logic             m_valid,
    input  logic             m_ready,
    output ffla_pkg::field_t m_granted_frame,
    output logic             m_out_of_memory,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  ffla_pkg::field_t cfg_wdata
);

    import ffla_pkg::*;

    mem_req_t mem_req;
    frame_t   mem_rdata;

    ffla_ctrl u_ctrl (
        .clk             (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_region_start  (s_region_start),
        .s_region_pages  (s_region_pages),
        .s_region_usable (s_region_usable),
        .s_release_frame (s_release_frame),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_granted_frame (m_granted_frame),
        .m_out_of_memory (m_out_of_memory),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_wdata       (cfg_wdata),
        .mem_req         (mem_req),
        .mem_rdata       (mem_rdata)
    );

    ffla_link_ram #(
        .ADDR_W (FRAME_BITS),
        .DATA_W (FRAME_BITS)
    ) u_link_ram (
        .clk   (aclk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

endmodule

// ===== sv/ffla_checker.sv =====
// ----------------------------------------------------------------------------
// Frame free list allocator: port checker
// Concurrent checks on the allocator ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "frame_free_list_allocator_defines.svh"

module ffla_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_granted_frame,
    input logic        m_out_of_memory
);

    // a stalled result word holds
    `FFLA_ASSERT(a_result_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_granted_frame) && $stable(m_out_of_memory))
    // out of memory never comes with a granted frame
    `FFLA_ASSERT(a_oom_no_frame, aclk, aresetn, m_valid && m_out_of_memory |-> m_granted_frame == 16'd0)
    // one item at a time: no accept right after an accept
    `FFLA_ASSERT(a_one_in_flight, aclk, aresetn, s_valid && s_ready |=> !s_ready)
    // reset empties the result register
    `FFLA_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_valid)

endmodule

bind frame_free_list_allocator ffla_checker u_ffla_checker (.*);
